/* rtl/plob_pkg.sv */
// types, codes and constants shared by the price-level order book
// no dependencies; compiled first
package plob_pkg;

  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned QTY_W    = 32;
  localparam int unsigned IN_QTY_W = 31;
  localparam int unsigned CODE_W   = 2;

  // op codes
  localparam logic [CODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [CODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [CODE_W-1:0] OP_DUMP   = 2'd2;

  // side codes
  localparam logic [CODE_W-1:0] SIDE_BID  = 2'd0;
  localparam logic [CODE_W-1:0] SIDE_ASK  = 2'd1;
  localparam logic [CODE_W-1:0] SIDE_NONE = 2'd2;

  // result kinds
  localparam logic [CODE_W-1:0] KIND_UPDATE = 2'd0;
  localparam logic [CODE_W-1:0] KIND_LEVEL  = 2'd1;
  localparam logic [CODE_W-1:0] KIND_EMPTY  = 2'd2;

  localparam logic signed [QTY_W-1:0] QTY_MAX = 32'sh7fff_ffff;
  localparam logic signed [QTY_W-1:0] QTY_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     valid;
    logic [PRICE_W-1:0]       price;
    logic signed [QTY_W-1:0]  qty;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_WRITE,
    CMD_ROT_UP,
    CMD_ROT_DN
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e                cmd;
    logic signed [QTY_W-1:0]  qty;
  } chain_ctrl_t;

  typedef struct packed {
    logic                     found;
    logic                     full;
    logic signed [QTY_W-1:0]  found_qty;
  } chain_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_APPLY,
    S_DUMP_BID,
    S_DUMP_ASK,
    S_EMPTY
  } state_e;

endpackage

/* rtl/plob_if.sv */
// valid/ready channel interfaces for the order book input and result streams
// depends on plob_pkg for field widths
interface plob_in_if;
  logic                                valid;
  logic                                ready;
  logic [plob_pkg::CODE_W-1:0]         op;
  logic [plob_pkg::CODE_W-1:0]         side;
  logic [plob_pkg::PRICE_W-1:0]        price;
  logic [plob_pkg::IN_QTY_W-1:0]       quantity;

  modport source (output valid, op, side, price, quantity, input ready);
  modport sink   (input valid, op, side, price, quantity, output ready);
endinterface

interface plob_out_if;
  logic                                valid;
  logic                                ready;
  logic [plob_pkg::CODE_W-1:0]         kind;
  logic [plob_pkg::CODE_W-1:0]         out_side;
  logic [plob_pkg::PRICE_W-1:0]        out_price;
  logic signed [plob_pkg::QTY_W-1:0]   level_quantity;
  logic                                level_removed;
  logic                                table_full;
  logic                                last;

  modport source (output valid, kind, out_side, out_price, level_quantity,
                  level_removed, table_full, last, input ready);
  modport sink   (input valid, kind, out_side, out_price, level_quantity,
                  level_removed, table_full, last, output ready);
endinterface

/* rtl/plob_cell.sv */
// one price level of a sorted side table, exchanging entries with its neighbors
// depends on plob_pkg
module plob_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  plob_pkg::cell_cmd_e               cmd_i,
  input  logic [plob_pkg::PRICE_W-1:0]      key_i,
  input  logic signed [plob_pkg::QTY_W-1:0] qty_i,
  input  plob_pkg::entry_t                  left_i,
  input  logic                              left_lt_i,
  input  plob_pkg::entry_t                  right_i,
  input  plob_pkg::entry_t                  wrap_i,
  output plob_pkg::entry_t                  entry_o,
  output logic                              lt_o,
  output logic                              eq_o
);
  import plob_pkg::*;

  logic                    valid_q, valid_d;
  logic [PRICE_W-1:0]      price_q, price_d;
  logic signed [QTY_W-1:0] qty_q, qty_d;
  entry_t                  cur;
  entry_t                  nxt;

  assign cur     = '{valid: valid_q, price: price_q, qty: qty_q};
  assign entry_o = cur;
  assign lt_o    = valid_q && (price_q < key_i);
  assign eq_o    = valid_q && (price_q == key_i);

  always_comb begin
    nxt = cur;
    case (cmd_i)
      CMD_INSERT: begin
        if (!lt_o) begin
          if (left_lt_i) begin
            nxt = '{valid: 1'b1, price: key_i, qty: qty_i};
          end else begin
            nxt = left_i;
          end
        end
      end
      CMD_DELETE: begin
        if (!lt_o) begin
          nxt = right_i;
        end
      end
      CMD_WRITE: begin
        if (eq_o) begin
          nxt.qty = qty_i;
        end
      end
      // rotations only move the live part of the table
      CMD_ROT_UP: begin
        if (valid_q) begin
          nxt = left_i;
        end
      end
      CMD_ROT_DN: begin
        if (valid_q) begin
          nxt = right_i.valid ? right_i : wrap_i;
        end
      end
      default: ;
    endcase
  end

  assign valid_d = nxt.valid;
  assign price_d = nxt.price;
  assign qty_d   = nxt.qty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    qty_q   <= qty_d;
  end

endmodule

/* rtl/plob_chain.sv */
// one side of the book: a row of level cells kept sorted by ascending price
// depends on plob_pkg and plob_cell
module plob_chain #(
  parameter int unsigned LEVELS = 32,
  parameter int unsigned CNT_W  = $clog2(LEVELS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [plob_pkg::PRICE_W-1:0] key_i,
  input  plob_pkg::chain_ctrl_t        ctrl_i,
  output plob_pkg::chain_stat_t        stat_o,
  output logic [CNT_W-1:0]             count_o,
  output plob_pkg::entry_t             head_o,
  output plob_pkg::entry_t             top_o
);
  import plob_pkg::*;

  entry_t             ent [LEVELS];
  logic [LEVELS-1:0]  lt;
  logic [LEVELS-1:0]  eq;
  logic [LEVELS-1:0]  vld;
  logic [LEVELS-1:0]  vld_above;
  logic [CNT_W-1:0]   count_q, count_d;
  entry_t             top;
  logic signed [QTY_W-1:0] found_qty;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    entry_t left;
    entry_t right;
    logic   left_lt;

    if (i == 0) begin : g_first
      // the bottom cell wraps around to the top live level
      assign left    = top;
      assign left_lt = 1'b1;
    end else begin : g_mid
      assign left    = ent[i-1];
      assign left_lt = lt[i-1];
    end

    if (i == LEVELS - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = ent[i+1];
    end

    plob_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (ctrl_i.cmd),
      .key_i     (key_i),
      .qty_i     (ctrl_i.qty),
      .left_i    (left),
      .left_lt_i (left_lt),
      .right_i   (right),
      .wrap_i    (ent[0]),
      .entry_o   (ent[i]),
      .lt_o      (lt[i]),
      .eq_o      (eq[i])
    );

    assign vld[i] = ent[i].valid;
  end

  assign vld_above = {1'b0, vld[LEVELS-1:1]};

  always_comb begin
    top       = '0;
    found_qty = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (vld[i] && !vld_above[i]) begin
        top = ent[i];
      end
      if (eq[i]) begin
        found_qty = found_qty | ent[i].qty;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    case (ctrl_i.cmd)
      CMD_INSERT: count_d = count_q + CNT_W'(1);
      CMD_DELETE: count_d = count_q - CNT_W'(1);
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.found     = |eq;
  assign stat_o.full      = (count_q == CNT_W'(LEVELS));
  assign stat_o.found_qty = found_qty;
  assign count_o          = count_q;
  assign head_o           = ent[0];
  assign top_o            = top;

  // live levels always fill the bottom of the row
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld + LEVELS'(1)) & vld) == '0)
    else $error("live levels not contiguous from the bottom cell");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld) == int'(count_q))
    else $error("level count out of step with live cells");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == CMD_INSERT |-> !stat_o.full && !stat_o.found)
    else $error("insert into a full side or onto an existing level");

  a_delete_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == CMD_DELETE |-> stat_o.found)
    else $error("delete without a matching level");

endmodule

/* rtl/price_level_order_book.sv */
// price-level order book top level: input capture, sequencer, result register
// depends on plob_pkg, plob_if and plob_chain
//
// Each side (bids, asks) is a row of LEVELS cells kept sorted by price; every
// cell compares its price with the incoming one at once, so an add or remove
// passes through its accept, lookup and apply states before the result is
// registered, the add and the saturation sitting in the apply cycle. Inserts
// and deletes shift the cells by one position in that same cycle. A dump
// rotates the live cells one position per cycle and emits one level per cycle
// while the output register can take it, bids from the highest price, then
// asks from the lowest; an empty book gives a single marker. One transaction
// is in the block at a time; a result waits in an output register and the
// block stalls while that register is full and not taken.
module price_level_order_book #(
  parameter int unsigned LEVELS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  plob_in_if.sink   in_i,
  plob_out_if.source out_o
);
  import plob_pkg::*;

  localparam int unsigned CNT_W = $clog2(LEVELS + 1);

  state_e                 state_q, state_d;
  logic                   in_acc;
  logic                   load_ok;
  logic                   out_load;

  // captured transaction
  logic                   is_remove_q;
  logic                   is_ask_q;
  logic [PRICE_W-1:0]     key_q;
  logic [IN_QTY_W-1:0]    qty_q;

  // lookup result
  logic                   found_q, found_d;
  logic                   sfull_q, sfull_d;
  logic signed [QTY_W-1:0] fqty_q, fqty_d;

  logic [CNT_W-1:0]       rem_q, rem_d;

  chain_ctrl_t            bid_ctrl, ask_ctrl;
  chain_stat_t            bid_stat, ask_stat, sel_stat;
  logic [CNT_W-1:0]       bid_cnt, ask_cnt;
  entry_t                 bid_head, bid_top, ask_head, ask_top;

  logic [QTY_W:0]         sum_wide;
  logic signed [QTY_W-1:0] sum_sat;
  logic                   sum_zero;
  cell_cmd_e              upd_cmd;

  // result register
  logic                    ovalid_q, ovalid_d;
  logic [CODE_W-1:0]       okind_q, okind_d;
  logic [CODE_W-1:0]       oside_q, oside_d;
  logic [PRICE_W-1:0]      oprice_q, oprice_d;
  logic signed [QTY_W-1:0] oqty_q, oqty_d;
  logic                    oremoved_q, oremoved_d;
  logic                    ofull_q, ofull_d;
  logic                    olast_q, olast_d;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_ok    = !ovalid_q || out_o.ready;

  plob_chain #(.LEVELS(LEVELS), .CNT_W(CNT_W)) u_bid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_i   (key_q),
    .ctrl_i  (bid_ctrl),
    .stat_o  (bid_stat),
    .count_o (bid_cnt),
    .head_o  (bid_head),
    .top_o   (bid_top)
  );

  plob_chain #(.LEVELS(LEVELS), .CNT_W(CNT_W)) u_ask (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_i   (key_q),
    .ctrl_i  (ask_ctrl),
    .stat_o  (ask_stat),
    .count_o (ask_cnt),
    .head_o  (ask_head),
    .top_o   (ask_top)
  );

  assign sel_stat = is_ask_q ? ask_stat : bid_stat;
  assign found_d  = sel_stat.found;
  assign sfull_d  = sel_stat.full;
  assign fqty_d   = sel_stat.found_qty;

  // level sum in 33 bits, then clamp to the signed 32-bit range
  always_comb begin
    if (is_remove_q) begin
      sum_wide = {fqty_q[QTY_W-1], fqty_q} - {2'b00, qty_q};
    end else begin
      sum_wide = {fqty_q[QTY_W-1], fqty_q} + {2'b00, qty_q};
    end
    if (sum_wide[QTY_W] != sum_wide[QTY_W-1]) begin
      sum_sat = sum_wide[QTY_W] ? QTY_MIN : QTY_MAX;
    end else begin
      sum_sat = sum_wide[QTY_W-1:0];
    end
    sum_zero = (sum_sat == '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.op == OP_DUMP) begin
            if (bid_cnt == '0 && ask_cnt == '0) begin
              state_d = S_EMPTY;
            end else if (bid_cnt != '0) begin
              state_d = S_DUMP_BID;
            end else begin
              state_d = S_DUMP_ASK;
            end
          end else if ((in_i.op inside {OP_ADD, OP_REMOVE}) &&
                       (in_i.side inside {SIDE_BID, SIDE_ASK})) begin
            state_d = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: state_d = S_APPLY;
      S_APPLY: begin
        if (load_ok) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP_BID: begin
        if (load_ok && rem_q == CNT_W'(1)) begin
          state_d = (ask_cnt != '0) ? S_DUMP_ASK : S_IDLE;
        end
      end
      S_DUMP_ASK: begin
        if (load_ok && rem_q == CNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (load_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // update command for the addressed side
  always_comb begin
    if (sum_zero) begin
      upd_cmd = found_q ? CMD_DELETE : CMD_HOLD;
    end else if (found_q) begin
      upd_cmd = CMD_WRITE;
    end else if (sfull_q) begin
      upd_cmd = CMD_HOLD;
    end else begin
      upd_cmd = CMD_INSERT;
    end
  end

  // outputs of the sequencer
  always_comb begin
    bid_ctrl   = '{cmd: CMD_HOLD, qty: sum_sat};
    ask_ctrl   = '{cmd: CMD_HOLD, qty: sum_sat};
    out_load   = 1'b0;
    rem_d      = rem_q;
    okind_d    = okind_q;
    oside_d    = oside_q;
    oprice_d   = oprice_q;
    oqty_d     = oqty_q;
    oremoved_d = oremoved_q;
    ofull_d    = ofull_q;
    olast_d    = olast_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rem_d = (bid_cnt != '0) ? bid_cnt : ask_cnt;
        end
      end
      S_APPLY: begin
        if (load_ok) begin
          out_load   = 1'b1;
          if (is_ask_q) begin
            ask_ctrl.cmd = upd_cmd;
          end else begin
            bid_ctrl.cmd = upd_cmd;
          end
          okind_d    = KIND_UPDATE;
          oside_d    = is_ask_q ? SIDE_ASK : SIDE_BID;
          oprice_d   = key_q;
          oqty_d     = (sum_zero || (!found_q && sfull_q)) ? '0 : sum_sat;
          oremoved_d = sum_zero;
          ofull_d    = !sum_zero && !found_q && sfull_q;
          olast_d    = 1'b1;
        end
      end
      S_DUMP_BID: begin
        if (load_ok) begin
          out_load     = 1'b1;
          bid_ctrl.cmd = CMD_ROT_UP;
          okind_d      = KIND_LEVEL;
          oside_d      = SIDE_BID;
          oprice_d     = bid_top.price;
          oqty_d       = bid_top.qty;
          oremoved_d   = 1'b0;
          ofull_d      = 1'b0;
          olast_d      = (rem_q == CNT_W'(1)) && (ask_cnt == '0);
          rem_d        = (rem_q == CNT_W'(1)) ? ask_cnt : rem_q - CNT_W'(1);
        end
      end
      S_DUMP_ASK: begin
        if (load_ok) begin
          out_load     = 1'b1;
          ask_ctrl.cmd = CMD_ROT_DN;
          okind_d      = KIND_LEVEL;
          oside_d      = SIDE_ASK;
          oprice_d     = ask_head.price;
          oqty_d       = ask_head.qty;
          oremoved_d   = 1'b0;
          ofull_d      = 1'b0;
          olast_d      = (rem_q == CNT_W'(1));
          rem_d        = rem_q - CNT_W'(1);
        end
      end
      S_EMPTY: begin
        if (load_ok) begin
          out_load   = 1'b1;
          okind_d    = KIND_EMPTY;
          oside_d    = SIDE_NONE;
          oprice_d   = '0;
          oqty_d     = '0;
          oremoved_d = 1'b0;
          ofull_d    = 1'b0;
          olast_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_remove_q <= (in_i.op == OP_REMOVE);
      is_ask_q    <= (in_i.side == SIDE_ASK);
      key_q       <= in_i.price;
      qty_q       <= in_i.quantity;
    end
    if (state_q == S_LOOKUP) begin
      found_q <= found_d;
      sfull_q <= sfull_d;
      fqty_q  <= fqty_d;
    end
    rem_q      <= rem_d;
    okind_q    <= okind_d;
    oside_q    <= oside_d;
    oprice_q   <= oprice_d;
    oqty_q     <= oqty_d;
    oremoved_q <= oremoved_d;
    ofull_q    <= ofull_d;
    olast_q    <= olast_d;
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.kind           = okind_q;
  assign out_o.out_side       = oside_q;
  assign out_o.out_price      = oprice_q;
  assign out_o.level_quantity = oqty_q;
  assign out_o.level_removed  = oremoved_q;
  assign out_o.table_full     = ofull_q;
  assign out_o.last           = olast_q;

  // the bid bottom cell and the ask top live level are filled exactly when that side has live levels
  a_bid_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bid_head.valid == (bid_cnt != '0))
    else $error("bid bottom cell out of step with bid count");

  a_ask_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ask_top.valid == (ask_cnt != '0))
    else $error("ask top cell out of step with ask count");

endmodule
